/* rtl/sfr_pkg.sv */
// types and constants shared by the serial frame receiver
`default_nettype none

package sfr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_HDR2 = 3'd1,
        PH_ADDR = 3'd2,
        PH_CMD  = 3'd3,
        PH_RESP = 3'd4,
        PH_DATA = 3'd5
    } phase_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    localparam logic [1:0] HIT_NONE   = 2'd0;
    localparam logic [1:0] HIT_FIRST  = 2'd1;
    localparam logic [1:0] HIT_SECOND = 2'd2;

    localparam logic [2:0] REG_FIRST_HEADER  = 3'd0;
    localparam logic [2:0] REG_SECOND_HEADER = 3'd1;
    localparam logic [2:0] REG_OWN_ADDRESS   = 3'd2;
    localparam logic [2:0] REG_END_MARKER    = 3'd3;
    localparam logic [2:0] REG_IDLE_TICKS    = 3'd4;
    localparam logic [2:0] REG_FRAME_LIMIT   = 3'd5;
    localparam logic [2:0] REG_CODE_FIRST    = 3'd6;
    localparam logic [2:0] REG_CODE_SECOND   = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;
    localparam int COUNT_W     = 6;
    localparam int TIMER_W     = 15;

    localparam logic [TIMER_W-1:0] IDLE_TICKS_RST  = 15'd5;
    localparam logic [COUNT_W-1:0] FRAME_LIMIT_RST = 6'd20;
    localparam logic [7:0]         CODE_FIRST_RST  = 8'h3E;
    localparam logic [7:0]         CODE_SECOND_RST = 8'h41;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_value;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         phase;
        logic [COUNT_W-1:0] position;
        logic [1:0]         command_hit;
        logic               frame_done;
        logic               restarted;
    } out_word_t;

endpackage

`default_nettype wire

/* rtl/serial_frame_receiver_with_timeout.sv */
// serial frame receiver: header, address and command tracking with inter-byte timeout
//
// Input channel (in_valid / in_stall / in_word) carries one word per item: a
// received byte or one timer tick. Each accepted word produces exactly one
// result word on the output channel (out_valid / out_stall / out_word) giving
// the frame phase and byte position after the word, a command hit code, an
// end-of-frame flag and a restart flag for a byte that arrived after timeout.
// The result is registered: an accepted word loads the result register at that
// edge. Throughput is one word per cycle unless a result waits under out_stall;
// the whole update is one pass of compares and a countdown decrement between
// the input and the result register. The result register doubles as the skid
// stage: a new word is taken whenever the result register is empty or is being
// drained, so in_stall is high only while a result waits and out_stall is high.
// Configuration writes (cfg_en / cfg_index / cfg_data) take effect at the
// edge and are meant for idle periods only.
// Reset clears the frame state, countdown, expired flag and output valid, and
// loads the register defaults (idle ticks 5, limit 20, codes 0x3E and 0x41).
`default_nettype none

module serial_frame_receiver_with_timeout (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire  sfr_pkg::in_word_t              in_word,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output sfr_pkg::out_word_t                   out_word,
    input  wire                                  cfg_en,
    input  wire  [sfr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [sfr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import sfr_pkg::*;

    // configuration
    logic [7:0]         first_header_reg;
    logic [7:0]         second_header_reg;
    logic [7:0]         own_address_reg;
    logic [7:0]         end_marker_reg;
    logic [TIMER_W-1:0] idle_ticks_reg;
    logic [COUNT_W-1:0] frame_limit_reg;
    logic [7:0]         code_first_reg;
    logic [7:0]         code_second_reg;

    // frame state
    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIMER_W-1:0] countdown_reg, countdown_next;
    logic               expired_reg, expired_next;

    // result stage
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    logic               accept;
    logic [1:0]         hit;
    logic               done;
    logic               restart;
    phase_t             phase_start;
    logic [COUNT_W-1:0] count_inc;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_header_reg  <= '0;
            second_header_reg <= '0;
            own_address_reg   <= '0;
            end_marker_reg    <= '0;
            idle_ticks_reg    <= IDLE_TICKS_RST;
            frame_limit_reg   <= FRAME_LIMIT_RST;
            code_first_reg    <= CODE_FIRST_RST;
            code_second_reg   <= CODE_SECOND_RST;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                REG_FIRST_HEADER:  first_header_reg  <= cfg_data[7:0];
                REG_SECOND_HEADER: second_header_reg <= cfg_data[7:0];
                REG_OWN_ADDRESS:   own_address_reg   <= cfg_data[7:0];
                REG_END_MARKER:    end_marker_reg    <= cfg_data[7:0];
                REG_IDLE_TICKS:    idle_ticks_reg    <= cfg_data[TIMER_W-1:0];
                REG_FRAME_LIMIT:   frame_limit_reg   <= cfg_data[COUNT_W-1:0];
                REG_CODE_FIRST:    code_first_reg    <= cfg_data[7:0];
                REG_CODE_SECOND:   code_second_reg   <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        countdown_next = countdown_reg;
        expired_next   = expired_reg;
        hit            = HIT_NONE;
        done           = 1'b0;
        restart        = 1'b0;
        phase_start    = phase_reg;
        count_inc      = '0;

        if (in_word.operation == OP_TICK)
        begin
            if (countdown_reg != '0)
            begin
                countdown_next = countdown_reg - 1'b1;
                if (countdown_reg == TIMER_W'(1))
                    expired_next = 1'b1;
            end
        end
        else
        begin
            // a byte after timeout starts over from idle
            if (expired_reg)
            begin
                expired_next = 1'b0;
                phase_start  = PH_IDLE;
                restart      = 1'b1;
            end
            count_inc      = (phase_start == PH_IDLE) ? COUNT_W'(1) : count_reg + 1'b1;
            count_next     = count_inc;
            countdown_next = idle_ticks_reg;
            phase_next     = phase_start;

            case (phase_start)
                PH_IDLE:
                begin
                    if (in_word.rx_value == first_header_reg)
                        phase_next = PH_HDR2;
                end
                PH_HDR2:
                    phase_next = (in_word.rx_value == second_header_reg) ? PH_ADDR : PH_IDLE;
                PH_ADDR:
                    phase_next = (in_word.rx_value == own_address_reg) ? PH_CMD : PH_IDLE;
                PH_CMD:
                begin
                    phase_next = PH_RESP;
                    if (in_word.rx_value == code_first_reg)
                        hit = HIT_FIRST;
                    else if (in_word.rx_value == code_second_reg)
                        hit = HIT_SECOND;
                end
                PH_RESP:
                    phase_next = PH_DATA;
                PH_DATA:
                begin
                    if (in_word.rx_value == end_marker_reg || count_inc >= frame_limit_reg)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end

        out_word_next.phase       = phase_next;
        out_word_next.position    = count_next;
        out_word_next.command_hit = hit;
        out_word_next.frame_done  = done;
        out_word_next.restarted   = restart;

        if (accept)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            countdown_reg <= '0;
            expired_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                countdown_reg <= countdown_next;
                expired_reg   <= expired_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // expired flag only ever stands with an empty countdown
    a_expired_empty: assert property (@(posedge clk) disable iff (!rst_n)
        expired_reg |-> countdown_reg == '0)
        else $error("expired flag set with countdown running");

    // a restarting byte is always the first byte of a new attempt
    a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.restarted) |->
            (out_word_reg.position == COUNT_W'(1)
             && (out_word_reg.phase == PH_IDLE || out_word_reg.phase == PH_HDR2)))
        else $error("restart result not at frame start");

    // a command hit only comes from the fourth byte of a frame
    a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.command_hit != HIT_NONE) |->
            (out_word_reg.phase == PH_RESP && out_word_reg.position == COUNT_W'(4)))
        else $error("command hit outside command byte");

    // end of frame always returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.frame_done) |-> out_word_reg.phase == PH_IDLE)
        else $error("frame done without return to idle");

endmodule

`default_nettype wire

/* tb/serial_frame_receiver_with_timeout_tb.sv */
// self-checking testbench for the serial frame receiver with inter-byte timeout
`timescale 1ns / 100ps

module serial_frame_receiver_with_timeout_tb;

    import sfr_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned PHASE_BUDGET = 105;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_stall;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_word;
    logic                   cfg_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    serial_frame_receiver_with_timeout uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // register copies, loaded with the reset defaults
    logic [7:0]         want_hdr1 = 8'h00;
    logic [7:0]         want_hdr2 = 8'h00;
    logic [7:0]         want_addr = 8'h00;
    logic [7:0]         want_tail = 8'h00;
    logic [TIMER_W-1:0] reload_ticks = IDLE_TICKS_RST;
    logic [COUNT_W-1:0] cut_len = FRAME_LIMIT_RST;
    logic [7:0]         code_a = CODE_FIRST_RST;
    logic [7:0]         code_b = CODE_SECOND_RST;

    // frame tracking state of the predictor
    phase_t             trk_phase = PH_IDLE;
    logic [COUNT_W-1:0] trk_count = '0;
    logic [TIMER_W-1:0] trk_timer = '0;
    logic               trk_expired = 1'b0;

    in_word_t    word_backlog[$];
    out_word_t   status_due[$];

    int unsigned error_count = 0;
    int unsigned words_made = 0;
    int unsigned words_checked = 0;
    int unsigned frames_closed = 0;
    int unsigned restarts_seen = 0;
    int unsigned hits_seen = 0;
    int unsigned settings_run = 1;

    logic        in_taken = 1'b0;
    int unsigned send_gap = 0;
    int unsigned send_burst = 0;
    logic        drain_hold = 1'b0;
    int unsigned hold_left = 0;
    int unsigned calm_left = 0;
    int unsigned quiet_cycles = 0;

    function automatic out_word_t track_frame(input in_word_t w);
        out_word_t r;
        r = '0;
        if (w.operation == OP_TICK) begin
            if (trk_timer != 0) begin
                trk_timer = trk_timer - 1'b1;
                if (trk_timer == 0)
                    trk_expired = 1'b1;
            end
        end
        else begin
            if (trk_expired) begin
                trk_expired = 1'b0;
                trk_phase = PH_IDLE;
                r.restarted = 1'b1;
            end
            if (trk_phase == PH_IDLE)
                trk_count = '0;
            trk_count = trk_count + 1'b1;
            trk_timer = reload_ticks;
            case (trk_phase)
                PH_IDLE:
                    if (w.rx_value == want_hdr1)
                        trk_phase = PH_HDR2;
                PH_HDR2:
                    trk_phase = (w.rx_value == want_hdr2) ? PH_ADDR : PH_IDLE;
                PH_ADDR:
                    trk_phase = (w.rx_value == want_addr) ? PH_CMD : PH_IDLE;
                PH_CMD:
                begin
                    trk_phase = PH_RESP;
                    if (w.rx_value == code_a)
                        r.command_hit = HIT_FIRST;
                    else if (w.rx_value == code_b)
                        r.command_hit = HIT_SECOND;
                end
                PH_RESP:
                    trk_phase = PH_DATA;
                PH_DATA:
                    if (w.rx_value == want_tail || trk_count >= cut_len) begin
                        trk_phase = PH_IDLE;
                        r.frame_done = 1'b1;
                    end
                default:
                    trk_phase = PH_IDLE;
            endcase
        end
        r.phase = trk_phase;
        r.position = trk_count;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // sender
    always @(negedge clk) begin : feed
        int unsigned next_gap;
        int unsigned next_burst;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (drain_hold && status_due.size() != 0) begin
                in_valid <= 1'b0;
            end
            else if (word_backlog.size() != 0) begin
                in_word <= word_backlog.pop_front();
                in_valid <= 1'b1;
                next_burst = send_burst;
                if (next_burst != 0) begin
                    next_gap = 0;
                    next_burst--;
                end
                else begin
                    next_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        next_burst = $urandom_range(30, 80);
                end
                send_gap <= next_gap;
                send_burst <= next_burst;
                // now and then hold the next word until every result is back
                drain_hold <= ($urandom_range(0, 99) == 0);
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk) begin : backpress
        int unsigned n;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (calm_left != 0) begin
            out_stall <= 1'b0;
            calm_left <= calm_left - 1;
        end
        else if ($urandom_range(0, 99) == 0) begin
            out_stall <= 1'b0;
            calm_left <= $urandom_range(40, 100);
        end
        else begin
            n = ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
            out_stall <= (n != 0);
            hold_left <= (n != 0) ? n - 1 : 0;
        end
    end

    // acceptance, prediction and comparison
    always @(posedge clk) begin : watch
        out_word_t want;
        out_word_t made;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end
        else begin
            in_taken <= in_valid && !in_stall;
            if (out_valid && !out_stall) begin
                if (status_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected word: expected none, actual %h", $time, out_word);
                end
                else begin
                    want = status_due.pop_front();
                    words_checked++;
                    check_field("phase", want.phase, out_word.phase);
                    check_field("position", want.position, out_word.position);
                    check_field("command_hit", want.command_hit, out_word.command_hit);
                    check_field("frame_done", want.frame_done, out_word.frame_done);
                    check_field("restarted", want.restarted, out_word.restarted);
                end
            end
            if (in_valid && !in_stall) begin
                made = track_frame(in_word);
                status_due.push_back(made);
                frames_closed += made.frame_done;
                restarts_seen += made.restarted;
                hits_seen += (made.command_hit != HIT_NONE);
            end
        end
    end

    // watchdog: too long without any handshake
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        in_word_t w;
        w.operation = OP_BYTE;
        w.rx_value = b;
        word_backlog.push_back(w);
        words_made++;
    endtask

    task automatic push_ticks(input int unsigned n);
        in_word_t w;
        repeat (n) begin
            w.operation = OP_TICK;
            w.rx_value = 8'($urandom_range(0, 255));
            word_backlog.push_back(w);
            words_made++;
        end
    endtask

    // ticks between bytes: mostly none, some short of expiry, a few that expire
    task automatic gap_ticks();
        int unsigned r;
        int unsigned top;
        r = $urandom_range(0, 99);
        if (r < 20 && reload_ticks > 1) begin
            top = (reload_ticks > 4) ? 3 : reload_ticks - 1;
            push_ticks($urandom_range(1, top));
        end
        else if (r < 24 && reload_ticks != 0 && reload_ticks <= 40) begin
            push_ticks(reload_ticks + $urandom_range(0, 2));
        end
    endtask

    function automatic logic [7:0] plain_data();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == want_tail)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic gen_frame(input bit broken);
        logic [7:0]  seq[$];
        int unsigned r;
        int unsigned n;
        int unsigned keep;
        seq.push_back(want_hdr1);
        seq.push_back(want_hdr2);
        seq.push_back(want_addr);
        r = $urandom_range(0, 9);
        seq.push_back(r < 4 ? code_a : (r < 7 ? code_b : 8'($urandom_range(0, 255))));
        seq.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0) begin
            // run the data part out to the length limit
            n = (cut_len > 5) ? cut_len - 5 : 1;
            repeat (n) seq.push_back(plain_data());
        end
        else begin
            repeat ($urandom_range(0, 6)) seq.push_back(plain_data());
            seq.push_back(want_tail);
        end
        if (broken) begin
            keep = $urandom_range(1, seq.size() - 1);
            while (seq.size() > keep)
                void'(seq.pop_back());
            if ($urandom_range(0, 1) == 0)
                seq[keep-1] = 8'($urandom_range(0, 255));
        end
        foreach (seq[i]) begin
            gap_ticks();
            push_byte(seq[i]);
        end
    endtask

    task automatic random_part(input int unsigned budget);
        int unsigned start;
        int unsigned r;
        start = words_made;
        while (words_made - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                gen_frame(1'b0);
            else if (r < 85)
                gen_frame(1'b1);
            else
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1) == 0)
                        push_byte(8'($urandom_range(0, 255)));
                    else
                        push_ticks(1);
                end
        end
    endtask

    task automatic wait_drained();
        while (word_backlog.size() != 0 || in_valid || status_due.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_FIRST_HEADER:  want_hdr1 = value[7:0];
            REG_SECOND_HEADER: want_hdr2 = value[7:0];
            REG_OWN_ADDRESS:   want_addr = value[7:0];
            REG_END_MARKER:    want_tail = value[7:0];
            REG_IDLE_TICKS:    reload_ticks = value[TIMER_W-1:0];
            REG_FRAME_LIMIT:   cut_len = value[COUNT_W-1:0];
            REG_CODE_FIRST:    code_a = value[7:0];
            REG_CODE_SECOND:   code_b = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] h1, input logic [7:0] h2,
                                 input logic [7:0] addr, input logic [7:0] tail,
                                 input logic [TIMER_W-1:0] ticks,
                                 input logic [COUNT_W-1:0] lim,
                                 input logic [7:0] ca, input logic [7:0] cb);
        write_reg(REG_FIRST_HEADER, h1);
        write_reg(REG_SECOND_HEADER, h2);
        write_reg(REG_OWN_ADDRESS, addr);
        write_reg(REG_END_MARKER, tail);
        write_reg(REG_IDLE_TICKS, ticks);
        write_reg(REG_FRAME_LIMIT, lim);
        write_reg(REG_CODE_FIRST, ca);
        write_reg(REG_CODE_SECOND, cb);
        settings_run++;
    endtask

    initial begin : run
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at reset defaults: headers, address and tail all zero
        push_ticks(1);                  // tick with countdown already zero
        push_byte(8'hFF);               // idle byte that is not a header
        push_byte(8'h00);
        push_byte(8'hFF);               // wrong second header
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(CODE_FIRST_RST);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h00);               // tail closes the frame
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);               // wrong address
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(CODE_SECOND_RST);
        push_byte(8'h00);
        push_ticks(IDLE_TICKS_RST + 2); // expire, then tick with the flag already set
        push_byte(8'h00);               // restart, taken as a first header
        push_byte(8'h7F);
        random_part(PHASE_BUDGET);
        wait_drained();

        apply_setting(8'hAA, 8'h55, 8'h01, 8'h0D, 15'd3, 6'd6, 8'h03, 8'h10);
        random_part(PHASE_BUDGET);
        wait_drained();

        apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h7FFF, 6'd63, 8'hFF, 8'h00);
        random_part(PHASE_BUDGET);
        wait_drained();

        apply_setting(8'h00, 8'hFF, 8'h80, 8'h7F, 15'd1, 6'd6, 8'h00, 8'hFF);
        random_part(PHASE_BUDGET);
        wait_drained();

        // equal codes, a countdown that never runs, data cut on its first byte
        apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      15'd0, 6'd3, 8'h5A, 8'h5A);
        random_part(PHASE_BUDGET);
        wait_drained();

        repeat (3) begin
            apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 3) == 0) ? 15'($urandom_range(1, 32767))
                                                      : 15'($urandom_range(1, 20)),
                          6'($urandom_range(6, 63)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            random_part(PHASE_BUDGET);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        $display("checked %0d result words from %0d input words over %0d register settings",
                 words_checked, words_made, settings_run);
        $display("frames closed %0d, timeout restarts %0d, command hits %0d",
                 frames_closed, restarts_seen, hits_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sfr_pkg.sv
rtl/serial_frame_receiver_with_timeout.sv
tb/serial_frame_receiver_with_timeout_tb.sv
